@@ rtl/rrct_pkg.sv @@
// ----------------------------------------------------------------------------
// rrct_pkg: shared types and constants of the round robin completion block
// Sizes, the token that walks the cell row, cell control and result words.
// ----------------------------------------------------------------------------
`default_nettype none

package rrct_pkg;

  // Capacity of the process row and the width of a time value.
  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int TIME_W    = 16;
  // Simulated time holds a full set of maximal bursts.
  localparam int SIM_W     = TIME_W + CNT_W;
  // Fixed widths of the result fields.
  localparam int OUT_W     = 20;
  localparam int SUM_W     = 24;
  localparam int PIDX_W    = 4;
  localparam int PCNT_W    = 5;

  // Reset value of the quantum register.
  localparam logic [TIME_W-1:0] QUANTUM_RESET = TIME_W'(4);

  // What the token does in the cell that holds it.
  typedef enum logic [1:0] {
    MODE_SCHED,
    MODE_SUM,
    MODE_EMIT
  } mode_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_INIT,
    ST_RUN
  } state_e;

  // Token word handed from one cell to the next.
  typedef struct packed {
    logic             tok;
    mode_e            mode;
    logic             active;
    logic [SIM_W-1:0] now;
    logic [SUM_W-1:0] sum_w;
    logic [SUM_W-1:0] sum_t;
  } link_t;

  // Per-cell control from the controller.
  typedef struct packed {
    logic load;
    logic init;
    logic in_set;
  } ctl_t;

  // Result word of one cell.
  typedef struct packed {
    logic             valid;
    logic [SIM_W-1:0] comp;
    logic [SIM_W-1:0] wt;
    logic [SIM_W:0]   tat;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/rrct_cell.sv @@
// ----------------------------------------------------------------------------
// rrct_cell: one process slot of the round robin row
// Holds burst, arrival, remaining and completion time of one process and
// acts on the token word as it passes on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rrct_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  rrct_pkg::ctl_t               ctl_i,
  input  wire  [rrct_pkg::TIME_W-1:0]  burst_i,
  input  wire  [rrct_pkg::TIME_W-1:0]  arrival_i,
  input  wire  [rrct_pkg::TIME_W-1:0]  quantum_i,
  input  rrct_pkg::link_t              link_i,
  output rrct_pkg::link_t              link_o,
  output rrct_pkg::res_t               res_o
);

  logic [rrct_pkg::TIME_W-1:0] burst_q, burst_d;
  logic [rrct_pkg::TIME_W-1:0] arrival_q, arrival_d;
  logic [rrct_pkg::TIME_W-1:0] rem_q, rem_d;
  logic [rrct_pkg::SIM_W-1:0]  comp_q, comp_d;
  logic [rrct_pkg::TIME_W:0]   used;
  logic [rrct_pkg::SIM_W-1:0]  used_ext;
  logic [rrct_pkg::SIM_W-1:0]  wt;
  logic [rrct_pkg::SIM_W:0]    tat;
  rrct_pkg::link_t             link_q, link_d;
  rrct_pkg::res_t              res_q, res_d;

  // Waiting and turnaround time from the stored values.
  always_comb begin
    used     = {1'b0, burst_q} + {1'b0, arrival_q};
    used_ext = rrct_pkg::SIM_W'(used);
    if (burst_q != '0 && comp_q > used_ext) begin
      wt = comp_q - used_ext;
    end else begin
      wt = '0;
    end
    tat = (rrct_pkg::SIM_W + 1)'(burst_q) + {1'b0, wt};
  end

  // Token handling: one quantum, one sum step or one result per visit.
  always_comb begin
    burst_d   = burst_q;
    arrival_d = arrival_q;
    rem_d     = rem_q;
    comp_d    = comp_q;
    link_d    = link_i;
    res_d     = '{valid: 1'b0, comp: comp_q, wt: wt, tat: tat};
    if (ctl_i.load) begin
      burst_d   = burst_i;
      arrival_d = arrival_i;
    end
    if (ctl_i.init) begin
      rem_d  = ctl_i.in_set ? burst_q : '0;
      comp_d = '0;
    end
    if (link_i.tok && ctl_i.in_set) begin
      unique case (link_i.mode)
        rrct_pkg::MODE_SCHED: begin
          if (rem_q != '0) begin
            link_d.active = 1'b1;
            if (rem_q > quantum_i) begin
              link_d.now = link_i.now + rrct_pkg::SIM_W'(quantum_i);
              rem_d      = rem_q - quantum_i;
            end else begin
              link_d.now = link_i.now + rrct_pkg::SIM_W'(rem_q);
              rem_d      = '0;
              comp_d     = link_i.now + rrct_pkg::SIM_W'(rem_q);
            end
          end
        end
        rrct_pkg::MODE_SUM: begin
          link_d.sum_w = link_i.sum_w + rrct_pkg::SUM_W'(wt);
          link_d.sum_t = link_i.sum_t + rrct_pkg::SUM_W'(tat);
        end
        rrct_pkg::MODE_EMIT: begin
          res_d.valid = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Process data needs no reset.
  always_ff @(posedge clk_i) begin
    burst_q   <= burst_d;
    arrival_q <= arrival_d;
    rem_q     <= rem_d;
    comp_q    <= comp_d;
  end

  // Token and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
      res_q  <= '0;
    end else begin
      link_q <= link_d;
      res_q  <= res_d;
    end
  end

  assign link_o = link_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

@@ rtl/round_robin_completion_times.sv @@
// ----------------------------------------------------------------------------
// round_robin_completion_times: round robin completion, waiting, turnaround
// Loads a process set into a row of cells, simulates round robin with a
// token that walks the row, then streams one result word per process.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Word
// process   in         start_i high, busy_o low  burst, arrival, last mark
// quantum   in         cfg_we_i high             16-bit time quantum
// result    out        result_valid_o one cycle  times, totals, count, last
//
// Loading takes one process word per cycle while busy_o is low. The word with
// the last mark raises busy_o; the init state follows, then the token walks
// the row of MAX_PROCS cells plus a head register in sweeps. A run has S + 3
// sweeps, S being the largest number of quanta any process needs; the extra
// sweeps are the final idle sweep, the totals sweep and the result sweep.
// Results come out one per cycle. Reset clears the set and the quantum goes
// to 4. The result side has no back pressure.

`default_nettype none

module round_robin_completion_times (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  output logic                          busy_o,
  input  wire  [rrct_pkg::TIME_W-1:0]   burst_time_i,
  input  wire  [rrct_pkg::TIME_W-1:0]   arrival_time_i,
  input  wire                           last_process_i,
  input  wire                           cfg_we_i,
  input  wire  [rrct_pkg::TIME_W-1:0]   cfg_data_i,
  output logic                          result_valid_o,
  output logic [rrct_pkg::PIDX_W-1:0]   process_index_o,
  output logic [rrct_pkg::OUT_W-1:0]    completion_time_o,
  output logic [rrct_pkg::OUT_W-1:0]    waiting_time_o,
  output logic [rrct_pkg::OUT_W-1:0]    turnaround_time_o,
  output logic [rrct_pkg::SUM_W-1:0]    total_waiting_o,
  output logic [rrct_pkg::SUM_W-1:0]    total_turnaround_o,
  output logic [rrct_pkg::PCNT_W-1:0]   process_count_o,
  output logic                          last_result_o
);

  rrct_pkg::state_e            state_q, state_d;
  logic [rrct_pkg::CNT_W-1:0]  count_q, count_d;
  logic [rrct_pkg::TIME_W-1:0] quant_q;
  logic [rrct_pkg::TIME_W-1:0] q_q;
  logic [rrct_pkg::IDX_W-1:0]  idx_q;
  logic [rrct_pkg::SUM_W-1:0]  tot_w_q, tot_t_q;
  rrct_pkg::link_t             head_q, head_d;
  rrct_pkg::link_t             links [rrct_pkg::MAX_PROCS+1];
  rrct_pkg::res_t              res [rrct_pkg::MAX_PROCS];
  rrct_pkg::res_t              res_any;
  rrct_pkg::link_t             tail;
  logic                        accept;
  logic                        init_run;
  logic                        capture;
  logic                        run_done;
  logic                        res_valid_q;
  logic                        last_q;
  logic [rrct_pkg::OUT_W-1:0]  comp_q, wt_q, tat_q;
  logic [rrct_pkg::IDX_W-1:0]  pidx_q;
  logic [rrct_pkg::PCNT_W-1:0] pcnt_q;

  assign accept   = start_i && !busy_o;
  assign links[0] = head_q;
  assign tail     = links[rrct_pkg::MAX_PROCS];

  // Row of process cells.
  for (genvar i = 0; i < rrct_pkg::MAX_PROCS; i++) begin : g_cell
    rrct_pkg::ctl_t ctl;
    assign ctl.load   = accept && (count_q == rrct_pkg::CNT_W'(i));
    assign ctl.init   = init_run;
    assign ctl.in_set = rrct_pkg::CNT_W'(i) < count_q;
    rrct_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .burst_i   (burst_time_i),
      .arrival_i (arrival_time_i),
      .quantum_i (q_q),
      .link_i    (links[i]),
      .link_o    (links[i+1]),
      .res_o     (res[i])
    );
  end

  // Only the cell holding an emit token shows a valid result.
  always_comb begin
    res_any = '0;
    for (int i = 0; i < rrct_pkg::MAX_PROCS; i++) begin
      if (res[i].valid) begin
        res_any = res_any | res[i];
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrct_pkg::ST_LOAD: begin
        if (accept && last_process_i) begin
          state_d = rrct_pkg::ST_INIT;
        end
      end
      rrct_pkg::ST_INIT: begin
        state_d = rrct_pkg::ST_RUN;
      end
      rrct_pkg::ST_RUN: begin
        if (tail.tok && tail.mode == rrct_pkg::MODE_EMIT) begin
          state_d = rrct_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = rrct_pkg::ST_LOAD;
      end
    endcase
  end

  // Controller outputs: token injection and sweep decisions at the row end.
  always_comb begin
    head_d   = '0;
    init_run = 1'b0;
    capture  = 1'b0;
    run_done = 1'b0;
    busy_o   = 1'b1;
    unique case (state_q)
      rrct_pkg::ST_LOAD: begin
        busy_o = 1'b0;
      end
      rrct_pkg::ST_INIT: begin
        init_run    = 1'b1;
        head_d.tok  = 1'b1;
        head_d.mode = rrct_pkg::MODE_SCHED;
      end
      rrct_pkg::ST_RUN: begin
        if (tail.tok) begin
          priority if (tail.mode == rrct_pkg::MODE_SCHED && tail.active) begin
            head_d.tok  = 1'b1;
            head_d.mode = rrct_pkg::MODE_SCHED;
            head_d.now  = tail.now;
          end else if (tail.mode == rrct_pkg::MODE_SCHED) begin
            head_d.tok  = 1'b1;
            head_d.mode = rrct_pkg::MODE_SUM;
          end else if (tail.mode == rrct_pkg::MODE_SUM) begin
            capture     = 1'b1;
            head_d.tok  = 1'b1;
            head_d.mode = rrct_pkg::MODE_EMIT;
          end else begin
            run_done = 1'b1;
          end
        end
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  // Set size: stored words are counted, extra words are dropped.
  always_comb begin
    count_d = count_q;
    if (run_done) begin
      count_d = '0;
    end else if (accept && count_q < rrct_pkg::CNT_W'(rrct_pkg::MAX_PROCS)) begin
      count_d = count_q + rrct_pkg::CNT_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrct_pkg::ST_LOAD;
      count_q     <= '0;
      quant_q     <= rrct_pkg::QUANTUM_RESET;
      head_q      <= '0;
      res_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      res_valid_q <= res_any.valid;
      if (cfg_we_i) begin
        quant_q <= cfg_data_i;
      end
      if (init_run) begin
        idx_q <= '0;
      end else if (res_any.valid) begin
        idx_q <= idx_q + rrct_pkg::IDX_W'(1);
      end
    end
  end

  // Quantum snapshot, totals and the output word. The set size is held with
  // the word, since the count clears before the final word of a full set.
  always_ff @(posedge clk_i) begin
    if (init_run) begin
      q_q <= (quant_q == '0) ? rrct_pkg::TIME_W'(1) : quant_q;
    end
    if (capture) begin
      tot_w_q <= tail.sum_w;
      tot_t_q <= tail.sum_t;
    end
    if (res_any.valid) begin
      comp_q <= res_any.comp[rrct_pkg::OUT_W-1:0];
      wt_q   <= res_any.wt[rrct_pkg::OUT_W-1:0];
      tat_q  <= res_any.tat[rrct_pkg::OUT_W-1:0];
      pidx_q <= idx_q;
      pcnt_q <= rrct_pkg::PCNT_W'(count_q);
      last_q <= (rrct_pkg::CNT_W'(idx_q) + rrct_pkg::CNT_W'(1)) == count_q;
    end
  end

  assign result_valid_o     = res_valid_q;
  assign process_index_o    = rrct_pkg::PIDX_W'(pidx_q);
  assign completion_time_o  = comp_q;
  assign waiting_time_o     = wt_q;
  assign turnaround_time_o  = tat_q;
  assign total_waiting_o    = tot_w_q;
  assign total_turnaround_o = tot_t_q;
  assign process_count_o    = pcnt_q;
  assign last_result_o      = last_q;

endmodule

`default_nettype wire

@@ rtl/rrct_checker.sv @@
// ----------------------------------------------------------------------------
// rrct_checker: port-level checks of the round robin completion block
// Watches busy, the result strobe and the result numbering over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rrct_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          start_i,
  input wire                          busy_o,
  input wire                          last_process_i,
  input wire                          result_valid_o,
  input wire [rrct_pkg::PIDX_W-1:0]   process_index_o,
  input wire [rrct_pkg::PCNT_W-1:0]   process_count_o,
  input wire                          last_result_o
);

  // The last word of a set starts a run.
  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_process_i |=> busy_o)
    else $error("run did not start after the last process word");

  // Every result but the final one arrives while the run is going.
  a_busy_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |-> busy_o)
    else $error("result word outside a run");

  // Result numbering stays inside the set.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ({1'b0, process_index_o} < process_count_o))
    else $error("result index beyond the set");

  // The final result carries the highest index.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_result_o |->
      ({1'b0, process_index_o} + 5'd1 == process_count_o))
    else $error("final result has the wrong index");

endmodule

bind round_robin_completion_times rrct_checker u_rrct_checker (.*);

`default_nettype wire
